// ----- rtl/rclfr_pkg.sv -----
// shared types and constants of the rc link frame receiver
package rclfr_pkg;

  localparam int StoreDepth = 22;
  localparam logic [7:0] CrcPoly = 8'hD5;
  localparam logic [10:0] SwitchHigh = 11'd1500;
  localparam logic [10:0] CursorLow = 11'd500;
  localparam logic [1:0] RegSync = 2'd0;
  localparam logic [1:0] RegMaxLength = 2'd1;
  localparam logic [1:0] RegChannelsType = 2'd2;

  typedef logic [StoreDepth*8-1:0] payload_t;

  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic near_to(input logic [10:0] v, input logic [10:0] c,
                                   input logic [10:0] tol);
    logic [11:0] d;
    d = (v >= c) ? ({1'b0, v} - {1'b0, c}) : ({1'b0, c} - {1'b0, v});
    return d <= {1'b0, tol};
  endfunction

endpackage

// ----- rtl/rc_link_frame_receiver_unit.sv -----
// top level of the rc link frame receiver
// usage:
//  - input channel: one link byte per transfer (in_valid, in_stall, rx_byte)
//  - output channel: one decoded rc channels frame per transfer (valid, stall)
//  - config port: cfg_we, cfg_index, cfg_data; index 0 sync, 1 max length,
//    2 channels type; write only while idle
//  - one byte per cycle when not stalled; parser updates crc in the same cycle
//  - a good channels frame passes the registered crc check, the frame queue
//    and the classification register, in that order, before its result
//    shows; an output stall can hold it in the queue
//  - a one-entry frame queue sits between parser and decoder; the input
//    stalls only while that queue is full and the output is full and stalled
//  - frame results are at least a whole frame of bytes apart, so the queue
//    never overflows while bytes keep flowing
//  - reset returns the parser to sync hunt, empties queue and output,
//    and restores register defaults
//  - while stall is high, the result holds and then backs up the queue
module rc_link_frame_receiver_unit import rclfr_pkg::*; #(
  parameter int ChannelFrameLength = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        valid,
  input  logic        stall,
  output logic [10:0] right_stick_horizontal,
  output logic [10:0] right_stick_vertical,
  output logic [10:0] left_stick_vertical,
  output logic [10:0] left_stick_horizontal,
  output logic [2:0]  two_way_switches,
  output logic [3:0]  three_way_switches,
  output logic signed [5:0] x_steps,
  output logic signed [5:0] y_steps,
  output logic [1:0]  cursor_position,
  output logic [10:0] pot_value,
  output logic [5:0]  trim_states
);

  logic [7:0] sync_value, max_frame_length, channels_type;
  logic       frame_done, frame_stall, in_take;
  payload_t   frame_payload;
  logic       q_full;
  payload_t   q_payload;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value <= 8'd200;
      max_frame_length <= 8'd62;
      channels_type <= 8'd22;
    end else if (cfg_we) begin
      case (cfg_index)
        RegSync: sync_value <= cfg_data;
        RegMaxLength: max_frame_length <= cfg_data;
        RegChannelsType: channels_type <= cfg_data;
        default: ;
      endcase
    end
  end

  // stall input while the frame queue is full and cannot drain
  assign in_stall = q_full && frame_stall;
  assign in_take = in_valid && !in_stall;

  rclfr_parser #(.ChannelFrameLength(ChannelFrameLength)) u_parser (
    .clk, .rst, .in_take, .rx_byte, .sync_value, .max_frame_length,
    .channels_type, .frame_done, .frame_payload
  );

  // one-entry frame queue between parser and decoder
  always_ff @(posedge clk) begin
    if (rst) q_full <= 1'b0;
    else if (frame_done) q_full <= 1'b1;
    else if (!frame_stall) q_full <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (frame_done) q_payload <= frame_payload;
  end

  rclfr_decoder u_decoder (
    .clk, .rst, .frame_valid(q_full), .frame_stall, .frame_payload(q_payload),
    .valid, .stall, .right_stick_horizontal, .right_stick_vertical,
    .left_stick_vertical, .left_stick_horizontal, .two_way_switches,
    .three_way_switches, .x_steps, .y_steps, .cursor_position, .pot_value,
    .trim_states
  );

endmodule

// ----- rtl/rclfr_parser.sv -----
// front part: frame parser with crc check, fills the payload register
module rclfr_parser import rclfr_pkg::*; #(
  parameter int ChannelFrameLength = 24
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_take,
  input  logic [7:0]     rx_byte,
  input  logic [7:0]     sync_value,
  input  logic [7:0]     max_frame_length,
  input  logic [7:0]     channels_type,
  output logic           frame_done,
  output payload_t       frame_payload
);

  typedef enum logic [2:0] {PhSync, PhLength, PhType, PhPayload, PhCrc} phase_t;

  phase_t     phase;
  logic [7:0] frame_length;
  logic [7:0] payload_count;
  logic [7:0] frame_type;
  logic [7:0] running_crc;
  logic [7:0] count_next;
  logic [8:0] count_sum;

  assign count_next = payload_count + 8'd1;
  assign count_sum = {1'b0, count_next} + 9'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PhSync;
      frame_length <= '0;
      payload_count <= '0;
      frame_type <= '0;
      running_crc <= '0;
      frame_done <= 1'b0;
    end else begin
      frame_done <= 1'b0;
      if (in_take) begin
        unique case (phase)
          PhSync: if (rx_byte == sync_value) phase <= PhLength;
          PhLength: begin
            frame_length <= rx_byte;
            if (rx_byte < 8'd2 || rx_byte > max_frame_length) begin
              phase <= PhSync;
            end else begin
              payload_count <= '0;
              running_crc <= '0;
              phase <= PhType;
            end
          end
          PhType: begin
            frame_type <= rx_byte;
            running_crc <= crc_step(running_crc, rx_byte);
            phase <= (frame_length == 8'd2) ? PhCrc : PhPayload;
          end
          PhPayload: begin
            running_crc <= crc_step(running_crc, rx_byte);
            payload_count <= count_next;
            if (count_sum >= {1'b0, frame_length}) phase <= PhCrc;
          end
          PhCrc: begin
            frame_done <= (rx_byte == running_crc) && (frame_type == channels_type) &&
                          (frame_length == 8'(ChannelFrameLength));
            phase <= PhSync;
          end
          default: phase <= PhSync;
        endcase
      end
    end
  end

  // payload bytes, stored at their byte position
  always_ff @(posedge clk) begin
    if (in_take && phase == PhPayload && payload_count < 8'(StoreDepth)) begin
      frame_payload[payload_count[4:0]*8 +: 8] <= rx_byte;
    end
  end

endmodule

// ----- rtl/rclfr_decoder.sv -----
// back part: channel unpack and classification, registered result
module rclfr_decoder import rclfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        frame_valid,
  output logic        frame_stall,
  input  payload_t    frame_payload,
  output logic        valid,
  input  logic        stall,
  output logic [10:0] right_stick_horizontal,
  output logic [10:0] right_stick_vertical,
  output logic [10:0] left_stick_vertical,
  output logic [10:0] left_stick_horizontal,
  output logic [2:0]  two_way_switches,
  output logic [3:0]  three_way_switches,
  output logic signed [5:0] x_steps,
  output logic signed [5:0] y_steps,
  output logic [1:0]  cursor_position,
  output logic [10:0] pot_value,
  output logic [5:0]  trim_states
);

  logic [10:0] ch [16];
  logic [175:0] bits;

  assign bits = frame_payload;
  always_comb begin
    for (int i = 0; i < 16; i++) ch[i] = bits[i*11 +: 11];
  end

  // centres two apart never overlap, so at most one even and one odd centre match:
  // each group is a plain or of its weights, and one add joins the two
  function automatic logic signed [5:0] steps(input logic [10:0] v);
    logic [10:0] cen [21];
    logic signed [5:0] s_even;
    logic signed [5:0] s_odd;
    cen = '{11'd186, 11'd254, 11'd330, 11'd416, 11'd500, 11'd582, 11'd664, 11'd742,
            11'd828, 11'd906, 11'd992, 11'd1076, 11'd1156, 11'd1240, 11'd1320,
            11'd1400, 11'd1482, 11'd1568, 11'd1654, 11'd1730, 11'd1796};
    s_even = '0;
    s_odd = '0;
    for (int i = 0; i < 21; i += 2) begin
      if (near_to(v, cen[i], 11'd35)) s_even = s_even | 6'(i - 10);
    end
    for (int i = 1; i < 21; i += 2) begin
      if (near_to(v, cen[i], 11'd35)) s_odd = s_odd | 6'(i - 10);
    end
    return s_even + s_odd;
  endfunction

  function automatic logic [1:0] three_way(input logic [10:0] v);
    if (near_to(v, 11'd172, 11'd35)) return 2'd0;
    if (near_to(v, 11'd992, 11'd35)) return 2'd1;
    return 2'd2;
  endfunction

  function automatic logic [2:0] trim(input logic [10:0] v);
    if (near_to(v, 11'd1760, 11'd100)) return 3'd1;
    if (near_to(v, 11'd1401, 11'd100)) return 3'd2;
    if (near_to(v, 11'd222, 11'd100)) return 3'd3;
    if (near_to(v, 11'd583, 11'd100)) return 3'd4;
    return 3'd0;
  endfunction

  assign frame_stall = valid && stall;

  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else if (frame_valid && !frame_stall) valid <= 1'b1;
    else if (!stall) valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (frame_valid && !frame_stall) begin
      right_stick_horizontal <= ch[0];
      right_stick_vertical <= ch[1];
      left_stick_vertical <= ch[2];
      left_stick_horizontal <= ch[3];
      two_way_switches <= {ch[4] > SwitchHigh, ch[10] > SwitchHigh, ch[11] > SwitchHigh};
      three_way_switches <= {three_way(ch[8]), three_way(ch[9])};
      x_steps <= steps(ch[5]);
      y_steps <= steps(ch[6]);
      cursor_position <= (ch[7] > SwitchHigh) ? 2'd2 : ((ch[7] < CursorLow) ? 2'd0 : 2'd1);
      pot_value <= ch[12];
      trim_states <= {trim(ch[13]), trim(ch[14])};
    end
  end

endmodule

// ----- sim/rc_frame_scoreboard.sv -----
// link-side crc helper and scoreboard that predicts and checks decoded rc frames
package rclfr_test_pkg;

  function automatic logic [7:0] crc8_d5(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ 8'hD5) : (c << 1);
    end
    return c;
  endfunction

endpackage

module rc_frame_scoreboard import rclfr_pkg::*; import rclfr_test_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        valid,
  input  logic        stall,
  input  logic [10:0] right_stick_horizontal,
  input  logic [10:0] right_stick_vertical,
  input  logic [10:0] left_stick_vertical,
  input  logic [10:0] left_stick_horizontal,
  input  logic [2:0]  two_way_switches,
  input  logic [3:0]  three_way_switches,
  input  logic signed [5:0] x_steps,
  input  logic signed [5:0] y_steps,
  input  logic [1:0]  cursor_position,
  input  logic [10:0] pot_value,
  input  logic [5:0]  trim_states,
  output int          errors,
  output int          pending
);

  typedef enum logic [2:0] {HUNT, LEN, KIND, BODY, CHECK} parse_state_t;

  typedef struct packed {
    logic [10:0] rsh;
    logic [10:0] rsv;
    logic [10:0] lsv;
    logic [10:0] lsh;
    logic [2:0]  sw2;
    logic [3:0]  sw3;
    logic [5:0]  xs;
    logic [5:0]  ys;
    logic [1:0]  cur;
    logic [10:0] pot;
    logic [5:0]  trim;
  } rc_frame_t;

  logic [7:0] sync_byte, max_len, chan_type;
  parse_state_t state;
  logic [7:0] flen, cnt, ftype, crc;
  logic [7:0] store [StoreDepth];
  rc_frame_t decoded_frames[$];
  int err_count;

  function automatic bit close_to(input int v, input int c, input int tol);
    return (v > c ? v - c : c - v) <= tol;
  endfunction

  function automatic logic [5:0] detent_sum(input int v);
    int centres[21] = '{186, 254, 330, 416, 500, 582, 664, 742, 828, 906, 992,
                        1076, 1156, 1240, 1320, 1400, 1482, 1568, 1654, 1730, 1796};
    int s;
    s = 0;
    for (int i = 0; i < 21; i++) begin
      if (close_to(v, centres[i], 35)) s += i - 10;
    end
    return s[5:0];
  endfunction

  function automatic logic [1:0] three_pos(input int v);
    if (close_to(v, 172, 35)) return 2'd0;
    if (close_to(v, 992, 35)) return 2'd1;
    return 2'd2;
  endfunction

  function automatic logic [2:0] trim_pos(input int v);
    if (close_to(v, 1760, 100)) return 3'd1;
    if (close_to(v, 1401, 100)) return 3'd2;
    if (close_to(v, 222, 100)) return 3'd3;
    if (close_to(v, 583, 100)) return 3'd4;
    return 3'd0;
  endfunction

  function automatic rc_frame_t unpack_channels();
    logic [175:0] flat;
    int ch [16];
    rc_frame_t f;
    for (int k = 0; k < StoreDepth; k++) flat[8*k +: 8] = store[k];
    for (int i = 0; i < 16; i++) ch[i] = flat[11*i +: 11];
    f.rsh = ch[0];
    f.rsv = ch[1];
    f.lsv = ch[2];
    f.lsh = ch[3];
    f.sw2 = {ch[4] > 1500, ch[10] > 1500, ch[11] > 1500};
    f.sw3 = {three_pos(ch[8]), three_pos(ch[9])};
    f.xs = detent_sum(ch[5]);
    f.ys = detent_sum(ch[6]);
    f.cur = (ch[7] > 1500) ? 2'd2 : ((ch[7] < 500) ? 2'd0 : 2'd1);
    f.pot = ch[12];
    f.trim = {trim_pos(ch[13]), trim_pos(ch[14])};
    return f;
  endfunction

  task automatic parse_byte(input logic [7:0] b);
    case (state)
      HUNT: if (b == sync_byte) state = LEN;
      LEN: begin
        flen = b;
        if (b < 2 || b > max_len) begin
          state = HUNT;
        end else begin
          cnt = 0;
          crc = 0;
          state = KIND;
        end
      end
      KIND: begin
        ftype = b;
        crc = crc8_d5(crc, b);
        state = (flen == 2) ? CHECK : BODY;
      end
      BODY: begin
        if (cnt < StoreDepth) store[cnt] = b;
        crc = crc8_d5(crc, b);
        cnt = cnt + 1;
        if (int'(cnt) + 2 >= int'(flen)) state = CHECK;
      end
      CHECK: begin
        if (b == crc && ftype == chan_type && flen == 24) decoded_frames.push_back(unpack_channels());
        state = HUNT;
      end
      default: state = HUNT;
    endcase
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    rc_frame_t e;
    if (rst) begin
      sync_byte = 8'd200;
      max_len = 8'd62;
      chan_type = 8'd22;
      state = HUNT;
      flen = 0;
      cnt = 0;
      ftype = 0;
      crc = 0;
      decoded_frames.delete();
      err_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegSync: sync_byte = cfg_data;
          RegMaxLength: max_len = cfg_data;
          RegChannelsType: chan_type = cfg_data;
          default: ;
        endcase
      end
      if (valid && !stall) begin
        if (decoded_frames.size() == 0) begin
          $display("%0t: unexpected frame result, expected none, actual rsh %0d", $time,
                   right_stick_horizontal);
          err_count++;
        end else begin
          e = decoded_frames.pop_front();
          check_field("right_stick_horizontal", e.rsh, right_stick_horizontal);
          check_field("right_stick_vertical", e.rsv, right_stick_vertical);
          check_field("left_stick_vertical", e.lsv, left_stick_vertical);
          check_field("left_stick_horizontal", e.lsh, left_stick_horizontal);
          check_field("two_way_switches", e.sw2, two_way_switches);
          check_field("three_way_switches", e.sw3, three_way_switches);
          check_field("x_steps", $signed(e.xs), x_steps);
          check_field("y_steps", $signed(e.ys), y_steps);
          check_field("cursor_position", e.cur, cursor_position);
          check_field("pot_value", e.pot, pot_value);
          check_field("trim_states", e.trim, trim_states);
        end
      end
      if (in_valid && !in_stall) parse_byte(rx_byte);
    end
    errors <= err_count;
    pending <= decoded_frames.size();
  end

endmodule

// ----- sim/rc_link_frame_receiver_unit_test.sv -----
// stimulus and verdict for the rc link frame receiver
module rc_link_frame_receiver_unit_test;
  import rclfr_pkg::*;
  import rclfr_test_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  rx_byte;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        valid;
  logic        stall;
  logic [10:0] right_stick_horizontal, right_stick_vertical;
  logic [10:0] left_stick_vertical, left_stick_horizontal;
  logic [2:0]  two_way_switches;
  logic [3:0]  three_way_switches;
  logic signed [5:0] x_steps, y_steps;
  logic [1:0]  cursor_position;
  logic [10:0] pot_value;
  logic [5:0]  trim_states;
  int          errors;
  int          pending;

  // stimulus-side copy of the register settings, used to build frames
  logic [7:0] cur_sync, cur_max, cur_type;
  int bytes_sent;
  int cycles;
  bit quiet;      // no idling on either side in the last part of the run
  bit hold_req;   // asks the output side for one long hold-off

  rc_link_frame_receiver_unit uut (.*);

  rc_frame_scoreboard scoreboard (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog, far above the slowest legal run
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 300000) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // output side: random stall bursts, plus one long hold-off on request
  initial begin
    stall = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // hold long enough that the frame queue fills and the input stalls
        stall <= 1;
        repeat (600) @(posedge clk);
        stall <= 0;
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall <= 1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        stall <= 0;
      end
    end
  end

  // one byte transfer, then maybe an idle burst
  task automatic put_byte(input logic [7:0] b);
    in_valid <= 1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // channel values aimed at the classification boundaries
  function automatic logic [10:0] pick_channel();
    int centres[21] = '{186, 254, 330, 416, 500, 582, 664, 742, 828, 906, 992,
                        1076, 1156, 1240, 1320, 1400, 1482, 1568, 1654, 1730, 1796};
    int trims[4] = '{1760, 1401, 222, 583};
    int v;
    case ($urandom_range(0, 9))
      1: v = centres[$urandom_range(0, 20)] + $urandom_range(0, 80) - 40;
      2: v = ($urandom_range(0, 1) ? 172 : 992) + $urandom_range(0, 80) - 40;
      3: v = trims[$urandom_range(0, 3)] + $urandom_range(0, 220) - 110;
      4: v = 1499 + $urandom_range(0, 3);
      5: v = 498 + $urandom_range(0, 3);
      6: v = $urandom_range(0, 1) ? 0 : 2047;
      default: v = $urandom_range(0, 2047);
    endcase
    return v[10:0];
  endfunction

  // fill: 0 random channels, 1 all zeros, 2 all ones
  task automatic send_frame(input int len, input logic [7:0] kind, input int fill,
                            input bit bad_crc);
    logic [175:0] flat;
    logic [7:0] crc, b;
    if (fill == 1) flat = '0;
    else if (fill == 2) flat = '1;
    else for (int i = 0; i < 16; i++) flat[11*i +: 11] = pick_channel();
    put_byte(cur_sync);
    put_byte(len[7:0]);
    crc = crc8_d5(8'd0, kind);
    put_byte(kind);
    for (int i = 0; i < len - 2; i++) begin
      b = (i < StoreDepth) ? flat[8*i +: 8] : 8'($urandom);
      crc = crc8_d5(crc, b);
      put_byte(b);
    end
    if (bad_crc) crc ^= 8'($urandom_range(1, 255));
    put_byte(crc);
  endtask

  // sync followed by an out-of-range length byte
  task automatic send_bad_length();
    int l;
    put_byte(cur_sync);
    case ($urandom_range(0, 2))
      0: l = 0;
      1: l = 1;
      default: l = (cur_max < 255) ? $urandom_range(cur_max + 1, 255) : 0;
    endcase
    put_byte(l[7:0]);
  endtask

  // register writes only once all results are out and the decoder has drained
  task automatic set_regs(input logic [7:0] s, input logic [7:0] m, input logic [7:0] t);
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= RegSync;
    cfg_data <= s;
    @(posedge clk);
    cfg_index <= RegMaxLength;
    cfg_data <= m;
    @(posedge clk);
    cfg_index <= RegChannelsType;
    cfg_data <= t;
    @(posedge clk);
    cfg_we <= 0;
    cur_sync = s;
    cur_max = m;
    cur_type = t;
  endtask

  task automatic random_traffic(input int target);
    int r;
    while (bytes_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 65) send_frame(24, cur_type, 0, $urandom_range(0, 9) == 0);
      else if (r < 72) send_frame(24, 8'($urandom), 0, 0);
      else if (r < 85) send_frame($urandom_range(2, 40), 8'($urandom), 0,
                                  $urandom_range(0, 3) == 0);
      else if (r < 93) send_bad_length();
      else repeat ($urandom_range(1, 8)) put_byte(8'($urandom));
    end
  endtask

  initial begin
    rst = 1;
    in_valid = 0;
    rx_byte = 0;
    cfg_we = 0;
    cfg_index = RegSync;
    cfg_data = 0;
    quiet = 0;
    hold_req = 0;
    bytes_sent = 0;
    cur_sync = 200;
    cur_max = 62;
    cur_type = 22;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: channel extremes, empty payload, bad lengths, long payload,
    // bad crc and foreign types
    send_frame(24, cur_type, 1, 0);
    send_frame(24, cur_type, 2, 0);
    send_frame(2, 8'h10, 0, 0);
    put_byte(cur_sync);
    put_byte(8'd0);
    put_byte(cur_sync);
    put_byte(8'd1);
    put_byte(cur_sync);
    put_byte(8'd63);
    send_frame(40, 8'h05, 0, 0);
    send_frame(24, cur_type, 0, 1);
    send_frame(24, 8'd23, 0, 0);
    send_frame(23, cur_type, 0, 0);

    // defaults, with the long output hold-off in the middle
    random_traffic(350);
    hold_req = 1;
    random_traffic(700);

    // extreme settings: sync 0, widest lengths, type 255
    set_regs(8'd0, 8'd255, 8'd255);
    random_traffic(1250);

    // opposite extreme: only empty-payload frames fit
    set_regs(8'd255, 8'd2, 8'd0);
    repeat (4) send_frame(2, 8'($urandom), 0, $urandom_range(0, 1));
    repeat (3) send_bad_length();

    // random sync and type, the channels length as the maximum
    set_regs(8'($urandom), 8'd24, 8'($urandom));
    random_traffic(1700);
    quiet = 1;
    random_traffic(1950);

    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rclfr_pkg.sv
rtl/rclfr_parser.sv
rtl/rclfr_decoder.sv
rtl/rc_link_frame_receiver_unit.sv
sim/rc_frame_scoreboard.sv
sim/rc_link_frame_receiver_unit_test.sv
